### rtl/lvm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvm_pkg
// shared constants of the look-at view matrix pipeline
// ----------------------------------------------------------------------------
package lvm_pkg;
    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;
    // prescaled vectors have their largest magnitude in [2^29, 2^30)
    localparam int NORM_BITS     = 30;
    localparam int SQ_BITS       = 2 * NORM_BITS + 2;
    localparam int ROOT_BITS     = NORM_BITS + 1;
endpackage

### rtl/look_at_view_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_at_view_matrix
// view matrix basis and translation from eye, target and up vectors
// ----------------------------------------------------------------------------
// Fully pipelined: one camera setup word is taken every cycle while the output
// is not stalled. Unit entries are signed 18-bit values with 16 fraction bits
// and the translations are Q16.16. The pipeline is an input register, six
// up-vector prescale stages, two normalise units of 60 stages each (prescale,
// sum of squares, one stage per square-root bit and one per quotient bit), two
// cross-product stages and six stages for the true up vector and the dot
// products. The whole pipeline holds while a result waits on the output.
// ----------------------------------------------------------------------------
module look_at_view_matrix #(
    parameter int WORD_BITS = lvm_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = lvm_pkg::FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, upref_x, upref_y,
    // upref_z
    input  logic [9*WORD_BITS-1:0] i_s_tdata,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // right_x, right_y, right_z, trueup_x, trueup_y, trueup_z, dir_x, dir_y,
    // dir_z, trans_right, trans_up, trans_dir, zero fill
    output logic [((9*(FRAC_BITS+2)+3*WORD_BITS+7)/8)*8-1:0] o_m_tdata,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready
);
    import lvm_pkg::*;

    localparam int W     = WORD_BITS;
    localparam int U     = FRAC_BITS + 2;
    localparam int DW    = W + 1;
    localparam int UB    = NORM_BITS + 1;
    localparam int RCB   = UB + U + 1;
    localparam int TCB   = 2 * U + 1;
    localparam int DPB   = U + W;
    localparam int DSB   = DPB + 3;
    localparam int SA    = 3 * DW + 3 * W;
    localparam int SB1   = 3 * UB + 3 * W;
    localparam int SB2   = 3 * U + 3 * W;
    localparam logic signed [DSB-1:0] D_HALF = DSB'(1) <<< (FRAC_BITS - 1);
    localparam logic [TCB:0] T_HALF = (TCB+1)'(1) << (FRAC_BITS - 1);
    localparam logic [TCB:0] T_LIM  = (TCB+1)'(1) << FRAC_BITS;
    localparam logic signed [U-1:0] U_ONE = U'(1) <<< FRAC_BITS;

    logic w_en;

    // ---- input word ----
    logic                r_v0;
    logic signed [W-1:0] r_eye0 [3];
    logic signed [DW-1:0] r_diff0 [3];
    logic signed [W-1:0] r_up0  [3];
    logic [SA-1:0]       w_sa;

    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_eye0[i]  <= $signed(i_s_tdata[i*W +: W]);
                r_diff0[i] <= DW'($signed(i_s_tdata[i*W +: W]))
                            - DW'($signed(i_s_tdata[(3+i)*W +: W]));
                r_up0[i]   <= $signed(i_s_tdata[(6+i)*W +: W]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sa[i*W +: W]             = r_eye0[i];
            w_sa[3*W + i*DW +: DW]     = r_diff0[i];
        end
    end

    // ---- up-vector prescale ----
    logic                 p_vld;
    logic [NORM_BITS-1:0] p_mag [3];
    logic [2:0]           p_neg;
    logic [SA-1:0]        p_side;
    logic signed [DW-1:0] w_diff [3];
    logic [SB1-1:0]       w_sb1;

    lvm_prescale #(
        .IN_BITS   (W),
        .SIDE_BITS (SA)
    ) u_up_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v0),
        .i_vec   (r_up0),
        .i_side  (w_sa),
        .o_valid (p_vld),
        .o_mag   (p_mag),
        .o_neg   (p_neg),
        .o_side  (p_side)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_diff[i]              = $signed(p_side[3*W + i*DW +: DW]);
            w_sb1[i*W +: W]        = p_side[i*W +: W];
            w_sb1[3*W + i*UB +: UB] = p_neg[i] ? -$signed({1'b0, p_mag[i]})
                                               : $signed({1'b0, p_mag[i]});
        end
    end

    // ---- direction ----
    logic                n1_vld;
    logic signed [U-1:0] n1_dir [3];
    logic [SB1-1:0]      n1_side;

    lvm_norm #(
        .IN_BITS   (DW),
        .FRAC_BITS (FRAC_BITS),
        .SIDE_BITS (SB1)
    ) u_norm_dir (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (p_vld),
        .i_vec   (w_diff),
        .i_side  (w_sb1),
        .o_valid (n1_vld),
        .o_unit  (n1_dir),
        .o_side  (n1_side)
    );

    // ---- cross(up, dir) ----
    logic                    r_vx1, r_vx2;
    logic signed [RCB-2:0]   r_xp  [6];
    logic signed [RCB-1:0]   r_rc  [3];
    logic signed [U-1:0]     r_dx1 [3];
    logic signed [U-1:0]     r_dx2 [3];
    logic [W*3-1:0]          r_ex1, r_ex2;
    logic signed [UB-1:0]    w_upv [3];
    logic [SB2-1:0]          w_sb2;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_upv[i] = $signed(n1_side[3*W + i*UB +: UB]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xp[0] <= w_upv[1] * n1_dir[2];
            r_xp[1] <= w_upv[2] * n1_dir[1];
            r_xp[2] <= w_upv[2] * n1_dir[0];
            r_xp[3] <= w_upv[0] * n1_dir[2];
            r_xp[4] <= w_upv[0] * n1_dir[1];
            r_xp[5] <= w_upv[1] * n1_dir[0];
            r_dx1   <= n1_dir;
            r_ex1   <= n1_side[3*W-1:0];
            for (int i = 0; i < 3; i++) begin
                r_rc[i] <= RCB'(r_xp[2*i]) - RCB'(r_xp[2*i+1]);
            end
            r_dx2 <= r_dx1;
            r_ex2 <= r_ex1;
        end
    end

    always_comb begin
        w_sb2[3*W-1:0] = r_ex2;
        for (int i = 0; i < 3; i++) begin
            w_sb2[3*W + i*U +: U] = r_dx2[i];
        end
    end

    // ---- right ----
    logic                n2_vld;
    logic signed [U-1:0] n2_right [3];
    logic [SB2-1:0]      n2_side;

    lvm_norm #(
        .IN_BITS   (RCB),
        .FRAC_BITS (FRAC_BITS),
        .SIDE_BITS (SB2)
    ) u_norm_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_vx2),
        .i_vec   (r_rc),
        .i_side  (w_sb2),
        .o_valid (n2_vld),
        .o_unit  (n2_right),
        .o_side  (n2_side)
    );

    // ---- true up and dot products ----
    logic                  r_vt1, r_vt2, r_vt3, r_vd1, r_vd2, r_out_vld;
    logic signed [U-1:0]   w_dir [3];
    logic signed [2*U-1:0] r_tp  [6];
    logic signed [TCB-1:0] r_tc  [3];
    logic signed [U-1:0]   r_tup [3];
    logic signed [U-1:0]   r_rt  [3][3];
    logic signed [U-1:0]   r_dt  [3][3];
    logic signed [W-1:0]   r_et  [3][3];
    logic signed [DPB-1:0] r_dp  [3][3];
    logic signed [U-1:0]   r_u1  [3][3];
    logic signed [DSB-1:0] r_ds  [3];
    logic signed [U-1:0]   r_u2  [3][3];
    logic signed [U-1:0]   r_o_unit [3][3];
    logic [W-1:0]          r_o_tr [3];
    logic signed [W-1:0]   w_eye [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_dir[i] = $signed(n2_side[3*W + i*U +: U]);
            w_eye[i] = $signed(n2_side[i*W +: W]);
        end
    end

    always_ff @(posedge i_clk) begin
        logic [TCB-1:0] tm;
        logic [TCB:0]   rm;
        logic signed [DSB-1:0] dot;
        logic signed [DSB:0]   t;
        if (w_en) begin
            r_tp[0] <= w_dir[1] * n2_right[2];
            r_tp[1] <= w_dir[2] * n2_right[1];
            r_tp[2] <= w_dir[2] * n2_right[0];
            r_tp[3] <= w_dir[0] * n2_right[2];
            r_tp[4] <= w_dir[0] * n2_right[1];
            r_tp[5] <= w_dir[1] * n2_right[0];
            r_rt[0] <= n2_right;
            r_dt[0] <= w_dir;
            r_et[0] <= w_eye;
            for (int i = 0; i < 3; i++) begin
                r_tc[i] <= TCB'(r_tp[2*i]) - TCB'(r_tp[2*i+1]);
            end
            r_rt[1] <= r_rt[0];
            r_dt[1] <= r_dt[0];
            r_et[1] <= r_et[0];
            for (int i = 0; i < 3; i++) begin
                tm = $unsigned(r_tc[i][TCB-1] ? -r_tc[i] : r_tc[i]);
                rm = ((TCB+1)'(tm) + T_HALF) >> FRAC_BITS;
                if (rm > T_LIM) begin
                    rm = T_LIM;
                end
                r_tup[i] <= r_tc[i][TCB-1] ? -$signed(U'(rm)) : $signed(U'(rm));
            end
            r_rt[2] <= r_rt[1];
            r_dt[2] <= r_dt[1];
            r_et[2] <= r_et[1];
            // dot products: right, true up, direction
            for (int i = 0; i < 3; i++) begin
                r_dp[0][i] <= r_rt[2][i] * r_et[2][i];
                r_dp[1][i] <= r_tup[i] * r_et[2][i];
                r_dp[2][i] <= r_dt[2][i] * r_et[2][i];
            end
            r_u1[0] <= r_rt[2];
            r_u1[1] <= r_tup;
            r_u1[2] <= r_dt[2];
            for (int j = 0; j < 3; j++) begin
                r_ds[j] <= DSB'(r_dp[j][0]) + DSB'(r_dp[j][1]) + DSB'(r_dp[j][2])
                         + D_HALF;
            end
            r_u2 <= r_u1;
            r_o_unit <= r_u2;
            for (int j = 0; j < 3; j++) begin
                dot = r_ds[j] >>> FRAC_BITS;
                t   = -((DSB+1)'(dot));
                if (t[DSB:W-1] == '0 || t[DSB:W-1] == '1) begin
                    r_o_tr[j] <= t[W-1:0];
                end else begin
                    r_o_tr[j] <= {t[DSB], {(W-1){!t[DSB]}}};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0      <= 1'b0;
            r_vx1     <= 1'b0;
            r_vx2     <= 1'b0;
            r_vt1     <= 1'b0;
            r_vt2     <= 1'b0;
            r_vt3     <= 1'b0;
            r_vd1     <= 1'b0;
            r_vd2     <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_v0      <= i_s_tvalid;
            r_vx1     <= n1_vld;
            r_vx2     <= r_vx1;
            r_vt1     <= n2_vld;
            r_vt2     <= r_vt1;
            r_vt3     <= r_vt2;
            r_vd1     <= r_vt3;
            r_vd2     <= r_vd1;
            r_out_vld <= r_vd2;
        end
    end

    always_comb begin
        o_m_tdata = '0;
        for (int g = 0; g < 3; g++) begin
            for (int i = 0; i < 3; i++) begin
                o_m_tdata[(3*g + i)*U +: U] = r_o_unit[g][i];
            end
            o_m_tdata[9*U + g*W +: W] = r_o_tr[g];
        end
    end
    assign o_m_tvalid = r_out_vld;

    // direction entries stay within plus and minus one
    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_o_unit[2][0] <= U_ONE && r_o_unit[2][0] >= -U_ONE &&
                        r_o_unit[2][1] <= U_ONE && r_o_unit[2][1] >= -U_ONE &&
                        r_o_unit[2][2] <= U_ONE && r_o_unit[2][2] >= -U_ONE))
        else $error("direction entry out of unit range");

    // eye on target gives a zero right vector and a zero direction translation
    a_dir_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_o_unit[2][0] == '0 && r_o_unit[2][1] == '0 &&
         r_o_unit[2][2] == '0) |->
        (r_o_unit[0][0] == '0 && r_o_unit[0][1] == '0 && r_o_unit[0][2] == '0 &&
         r_o_tr[2] == '0))
        else $error("zero direction with non-zero right or translation");

    // degenerate right vector forces zero true up and zero right and up translations
    a_right_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_o_unit[0][0] == '0 && r_o_unit[0][1] == '0 &&
         r_o_unit[0][2] == '0) |->
        (r_o_unit[1][0] == '0 && r_o_unit[1][1] == '0 && r_o_unit[1][2] == '0 &&
         r_o_tr[0] == '0 && r_o_tr[1] == '0))
        else $error("zero right with non-zero true up or translation");

    // a held result keeps the pipeline frozen, checked on r_vd2 and r_ds[0]
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> ($stable(r_vd2) && $stable(r_ds[0])))
        else $error("pipeline moved while output stalled");
endmodule

### rtl/lvm_prescale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvm_prescale
// pipelined block-normalising shift of a three-component vector: magnitudes
// are moved so the largest one lands in the top NORM_BITS window
// ----------------------------------------------------------------------------
module lvm_prescale #(
    parameter int IN_BITS   = 33,
    parameter int SIDE_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [IN_BITS-1:0]     i_vec [3],
    input  logic [SIDE_BITS-1:0]          i_side,
    output logic                          o_valid,
    output logic [lvm_pkg::NORM_BITS-1:0] o_mag [3],
    output logic [2:0]                    o_neg,
    output logic [SIDE_BITS-1:0]          o_side
);
    import lvm_pkg::*;

    localparam int W  = (IN_BITS > NORM_BITS) ? IN_BITS : NORM_BITS;
    localparam int LV = $clog2(W);

    logic [W-1:0]         r_mag  [LV+1][3];
    logic [2:0]           r_neg  [LV+1];
    logic [SIDE_BITS-1:0] r_side [LV+1];
    logic                 r_vld  [LV+1];
    logic [IN_BITS-1:0]   w_abs  [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_abs[i] = $unsigned(i_vec[i][IN_BITS-1] ? -i_vec[i] : i_vec[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LV; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k <= LV; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_mag[0][i] <= W'(w_abs[i]);
                r_neg[0][i] <= i_vec[i][IN_BITS-1];
            end
            r_side[0] <= i_side;
        end
    end

    // one shift distance per stage, largest first
    for (genvar k = 1; k <= LV; k++) begin : g_shift
        localparam int STEP = 1 << (LV - k);
        logic [W-1:0] w_or;
        logic         w_sh;
        assign w_or = r_mag[k-1][0] | r_mag[k-1][1] | r_mag[k-1][2];
        assign w_sh = ~|w_or[W-1 -: STEP];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 3; i++) begin
                    r_mag[k][i] <= w_sh ? (r_mag[k-1][i] << STEP) : r_mag[k-1][i];
                end
                r_neg[k]  <= r_neg[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_mag[i] = r_mag[LV][i][W-1 -: NORM_BITS];
        end
    end
    assign o_neg   = r_neg[LV];
    assign o_side  = r_side[LV];
    assign o_valid = r_vld[LV];
endmodule

### rtl/lvm_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvm_norm
// pipelined vector normalise: prescale, sum of squares, bit-pair square
// root and restoring division, one stage per root or quotient bit
// ----------------------------------------------------------------------------
module lvm_norm #(
    parameter int IN_BITS   = 33,
    parameter int FRAC_BITS = 16,
    parameter int SIDE_BITS = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic signed [IN_BITS-1:0] i_vec [3],
    input  logic [SIDE_BITS-1:0]      i_side,
    output logic                      o_valid,
    output logic signed [FRAC_BITS+1:0] o_unit [3],
    output logic [SIDE_BITS-1:0]      o_side
);
    import lvm_pkg::*;

    localparam int QB  = FRAC_BITS + 2;
    localparam int DB  = NORM_BITS + FRAC_BITS + 1;
    localparam int RB  = ROOT_BITS;
    localparam int RB2 = ROOT_BITS + 2;
    localparam int NL  = ROOT_BITS + QB + 4;

    logic                 p_vld;
    logic [NORM_BITS-1:0] p_mag [3];
    logic [2:0]           p_neg;
    logic [SIDE_BITS-1:0] p_side;

    lvm_prescale #(
        .IN_BITS   (IN_BITS),
        .SIDE_BITS (SIDE_BITS)
    ) u_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (i_valid),
        .i_vec   (i_vec),
        .i_side  (i_side),
        .o_valid (p_vld),
        .o_mag   (p_mag),
        .o_neg   (p_neg),
        .o_side  (p_side)
    );

    logic [NORM_BITS-1:0]   r_mag_d  [NL][3];
    logic [2:0]             r_neg_d  [NL];
    logic [SIDE_BITS-1:0]   r_side_d [NL];
    logic                   r_vld_d  [NL];
    logic [2*NORM_BITS-1:0] r_sq     [3];
    logic [SQ_BITS-1:0]     r_sum;
    logic [RB2-1:0]         r_rem    [ROOT_BITS];
    logic [ROOT_BITS-1:0]   r_root   [ROOT_BITS];
    logic [SQ_BITS-1:0]     r_sv     [ROOT_BITS];
    logic [DB-1:0]          r_dvd    [3];
    logic [RB-1:0]          r_dvs;
    logic                   r_nz;
    logic [RB-1:0]          r_qr     [QB][3];
    logic [QB-1:0]          r_ql     [QB][3];
    logic [QB-1:0]          r_qq     [QB][3];
    logic [RB-1:0]          r_qn     [QB];
    logic                   r_qz     [QB];
    logic signed [QB-1:0]   r_unit   [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NL; k++) begin
                r_vld_d[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld_d[0] <= p_vld;
            for (int k = 1; k < NL; k++) begin
                r_vld_d[k] <= r_vld_d[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag_d[0]  <= p_mag;
            r_neg_d[0]  <= p_neg;
            r_side_d[0] <= p_side;
            for (int k = 1; k < NL; k++) begin
                r_mag_d[k]  <= r_mag_d[k-1];
                r_neg_d[k]  <= r_neg_d[k-1];
                r_side_d[k] <= r_side_d[k-1];
            end
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= (2*NORM_BITS)'(p_mag[i]) * (2*NORM_BITS)'(p_mag[i]);
            end
            r_sum <= SQ_BITS'(r_sq[0]) + SQ_BITS'(r_sq[1]) + SQ_BITS'(r_sq[2]);
        end
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < ROOT_BITS; k++) begin : g_root
        logic [RB2-1:0]       w_rem_in;
        logic [ROOT_BITS-1:0] w_root_in;
        logic [SQ_BITS-1:0]   w_s_in;
        logic [RB2+1:0]       w_cur;
        logic [RB2+1:0]       w_trial;
        logic                 w_ge;
        if (k == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_s_in    = r_sum;
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_root_in = r_root[k-1];
            assign w_s_in    = r_sv[k-1];
        end
        assign w_cur   = {w_rem_in, w_s_in[SQ_BITS-1-2*k -: 2]};
        assign w_trial = (RB2+2)'({w_root_in, 2'b01});
        assign w_ge    = (w_cur >= w_trial);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= RB2'(w_ge ? (w_cur - w_trial) : w_cur);
                r_root[k] <= {w_root_in[ROOT_BITS-2:0], w_ge};
                r_sv[k]   <= w_s_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_dvd[i] <= (DB'(r_mag_d[ROOT_BITS+1][i]) << FRAC_BITS)
                          + DB'(r_root[ROOT_BITS-1] >> 1);
            end
            r_dvs <= r_root[ROOT_BITS-1];
            r_nz  <= |r_root[ROOT_BITS-1];
        end
    end

    // restoring division, one quotient bit per stage, three lanes
    for (genvar j = 0; j < QB; j++) begin : g_div
        logic [RB-1:0] w_rem_in [3];
        logic [QB-1:0] w_low_in [3];
        logic [QB-1:0] w_q_in   [3];
        logic [RB-1:0] w_n_in;
        logic          w_z_in;
        if (j == 0) begin : g_first
            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    w_rem_in[i] = RB'(r_dvd[i][DB-1:QB]);
                    w_low_in[i] = r_dvd[i][QB-1:0];
                    w_q_in[i]   = '0;
                end
            end
            assign w_n_in = r_dvs;
            assign w_z_in = r_nz;
        end else begin : g_next
            assign w_rem_in = r_qr[j-1];
            assign w_low_in = r_ql[j-1];
            assign w_q_in   = r_qq[j-1];
            assign w_n_in   = r_qn[j-1];
            assign w_z_in   = r_qz[j-1];
        end
        always_ff @(posedge i_clk) begin
            logic [RB:0] t;
            logic        ge;
            if (i_en) begin
                for (int i = 0; i < 3; i++) begin
                    t  = {w_rem_in[i], w_low_in[i][QB-1-j]};
                    ge = (t >= {1'b0, w_n_in});
                    r_qr[j][i] <= RB'(ge ? (t - {1'b0, w_n_in}) : t);
                    r_qq[j][i] <= {w_q_in[i][QB-2:0], ge};
                end
                r_ql[j] <= w_low_in;
                r_qn[j] <= w_n_in;
                r_qz[j] <= w_z_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                if (!r_qz[QB-1]) begin
                    r_unit[i] <= '0;
                end else if (r_neg_d[NL-2][i]) begin
                    r_unit[i] <= -$signed(r_qq[QB-1][i]);
                end else begin
                    r_unit[i] <= $signed(r_qq[QB-1][i]);
                end
            end
        end
    end

    assign o_unit  = r_unit;
    assign o_side  = r_side_d[NL-1];
    assign o_valid = r_vld_d[NL-1];
endmodule

### tb/sv/look_at_view_matrix_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_at_view_matrix_tb
// self-checking bench for the look-at view matrix pipeline
// ----------------------------------------------------------------------------
// Camera setups, directed corner cases first and then random ones, are sent
// over the input stream. Each accepted word is run through a fixed-point
// model of the basis and translation maths. Each result word is compared,
// field by field, with the oldest prediction. Both sides of the stream stall
// at random.
// ----------------------------------------------------------------------------
module look_at_view_matrix_tb;
    localparam int W     = lvm_pkg::WORD_BITS_DEF;
    localparam int F     = lvm_pkg::FRAC_BITS_DEF;
    localparam int U     = F + 2;
    localparam int IN_W  = 9 * W;
    localparam int OUT_W = ((9 * U + 3 * W + 7) / 8) * 8;
    localparam int N_RANDOM   = 1830;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN      = 300;

    typedef logic [IN_W-1:0]  setup_t;
    typedef logic [OUT_W-1:0] matrix_t;

    class view_scoreboard;
        matrix_t pending[$];
        int      mismatches = 0;

        function longint unsigned mag(longint v);
            return v < 0 ? longint'(-v) : v;
        endfunction

        function void prescale(ref longint v[3]);
            longint unsigned m = 0;
            longint unsigned a;
            int len = 0;
            for (int i = 0; i < 3; i++) if (mag(v[i]) > m) m = mag(v[i]);
            if (m == 0) return;
            while (m != 0) begin
                len++;
                m >>= 1;
            end
            for (int i = 0; i < 3; i++) begin
                a = mag(v[i]);
                if (len < lvm_pkg::NORM_BITS) a <<= (lvm_pkg::NORM_BITS - len);
                else a >>= (len - lvm_pkg::NORM_BITS);
                v[i] = v[i] < 0 ? -longint'(a) : longint'(a);
            end
        endfunction

        function longint unsigned root(longint unsigned s);
            longint unsigned r = 0;
            longint unsigned b = 64'd1 << 62;
            while (b > s) b >>= 2;
            while (b != 0) begin
                if (s >= r + b) begin
                    s -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function void unit_vec(input longint v[3], output longint u[3]);
            longint w[3];
            longint unsigned s = 0;
            longint unsigned n, q;
            w = v;
            prescale(w);
            for (int i = 0; i < 3; i++) s += mag(w[i]) * mag(w[i]);
            if (s == 0) begin
                u = '{0, 0, 0};
                return;
            end
            n = root(s);
            for (int i = 0; i < 3; i++) begin
                q = ((mag(w[i]) << F) + n / 2) / n;
                u[i] = w[i] < 0 ? -longint'(q) : longint'(q);
            end
        endfunction

        function void cross3(input longint a[3], input longint b[3], output longint c[3]);
            c[0] = a[1] * b[2] - a[2] * b[1];
            c[1] = a[2] * b[0] - a[0] * b[2];
            c[2] = a[0] * b[1] - a[1] * b[0];
        endfunction

        // translation: exact dot split into integer and fraction parts of eye
        function logic [W-1:0] neg_dot(input longint u[3], input longint e[3]);
            longint hi = 0, lo = 0, el, x, fl, t;
            longint maxv = (longint'(1) << (W - 1)) - 1;
            for (int i = 0; i < 3; i++) begin
                el = e[i] & ((longint'(1) << F) - 1);
                hi += ((e[i] - el) >>> F) * u[i];
                lo += el * u[i];
            end
            x = lo + (longint'(1) << (F - 1));
            fl = x >= 0 ? (x >>> F) : -longint'((mag(x) + (64'd1 << F) - 1) >> F);
            t = -(hi + fl);
            if (t > maxv) t = maxv;
            if (t < -maxv - 1) t = -maxv - 1;
            return t[W-1:0];
        endfunction

        function matrix_t predict(setup_t d);
            longint eye[3], up[3], diff[3], dir[3], rc[3], rgt[3], tc[3], tup[3];
            longint unsigned m;
            matrix_t r = '0;
            for (int i = 0; i < 3; i++) begin
                eye[i]  = longint'($signed(d[i*W +: W]));
                diff[i] = eye[i] - longint'($signed(d[(3+i)*W +: W]));
                up[i]   = longint'($signed(d[(6+i)*W +: W]));
            end
            unit_vec(diff, dir);
            prescale(up);
            cross3(up, dir, rc);
            unit_vec(rc, rgt);
            cross3(dir, rgt, tc);
            for (int i = 0; i < 3; i++) begin
                m = (mag(tc[i]) + (64'd1 << (F - 1))) >> F;
                if (m > (64'd1 << F)) m = 64'd1 << F;
                tup[i] = tc[i] < 0 ? -longint'(m) : longint'(m);
            end
            for (int i = 0; i < 3; i++) begin
                r[i*U +: U]     = rgt[i][U-1:0];
                r[(3+i)*U +: U] = tup[i][U-1:0];
                r[(6+i)*U +: U] = dir[i][U-1:0];
            end
            r[9*U +: W]       = neg_dot(rgt, eye);
            r[9*U + W +: W]   = neg_dot(tup, eye);
            r[9*U + 2*W +: W] = neg_dot(dir, eye);
            return r;
        endfunction

        function void note_setup(setup_t d);
            pending.push_back(predict(d));
        endfunction

        function void check_matrix(matrix_t got);
            matrix_t want;
            int lo, wd;
            bit bad = 0;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", got);
                return;
            end
            want = pending.pop_front();
            for (int f = 0; f < 12; f++) begin
                lo = f < 9 ? f * U : 9 * U + (f - 9) * W;
                wd = f < 9 ? U : W;
                for (int b = 0; b < wd; b++)
                    if (got[lo + b] !== want[lo + b]) bad = 1;
                if (bad) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("field %0d mismatch: expected %h got %h", f,
                                 (want >> lo) & ((matrix_t'(1) << wd) - 1),
                                 (got >> lo) & ((matrix_t'(1) << wd) - 1));
                    bad = 0;
                end
            end
        endfunction
    endclass

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    setup_t  s_tdata = '0;
    logic    s_tvalid = 1'b0;
    logic    s_tready;
    matrix_t m_tdata;
    logic    m_tvalid;
    logic    m_tready = 1'b0;

    view_scoreboard board = new();
    int  idle_cycles = 0;
    int  cycle = 0;
    bit  calm = 0;

    always #5 i_clk = ~i_clk;

    look_at_view_matrix dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (s_tdata),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready)
    );

    // result side: random back-pressure, none while the calm stretch runs
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) board.check_matrix(m_tdata);
            m_tready <= calm || ($urandom_range(99) >= 24);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && !((s_tvalid && s_tready) || (m_tvalid && m_tready)))
            idle_cycles <= idle_cycles + 1;
        else
            idle_cycles <= 0;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("look_at_view_matrix regression: fail");
            $finish;
        end
    end

    function automatic logic [W-1:0] rnd_word();
        case ($urandom_range(3))
            0: return $urandom;
            1: return W'($signed($urandom_range(2 * 65536 * 8)) - 65536 * 8);
            2: return W'($signed($urandom_range(200)) - 100) << F;
            default: return W'($signed($urandom_range(2000)) - 1000);
        endcase
    endfunction

    // sends one word, valid stays high from word to word unless idling
    task automatic send_setup(setup_t d);
        while (!calm && $urandom_range(99) < 24) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge i_clk); while (!s_tready);
        board.note_setup(d);
    endtask

    task automatic send_vectors(logic [W-1:0] e[3], logic [W-1:0] t[3], logic [W-1:0] u[3]);
        send_setup({u[2], u[1], u[0], t[2], t[1], t[0], e[2], e[1], e[0]});
    endtask

    localparam logic [W-1:0] ONE  = 1 << F;
    localparam logic [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};

    initial begin
        logic [W-1:0] e[3], t[3], u[3];
        setup_t d;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners
        send_vectors('{0, 0, 5 * ONE}, '{0, 0, 0}, '{0, ONE, 0});
        send_vectors('{3 * ONE, 2 * ONE, ONE}, '{3 * ONE, 2 * ONE, ONE}, '{0, ONE, 0});
        send_vectors('{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0});
        send_vectors('{ONE, 2 * ONE, 3 * ONE}, '{0, 0, 0}, '{0, 0, 0});
        send_vectors('{0, 4 * ONE, 0}, '{0, 0, 0}, '{0, ONE, 0});
        send_vectors('{0, 4 * ONE, 0}, '{0, 0, 0}, '{0, -ONE, 0});
        send_vectors('{MAXW, MAXW, MAXW}, '{0, 0, 0}, '{0, ONE, 0});
        send_vectors('{MINW, MINW, MINW}, '{MAXW, MAXW, MAXW}, '{MINW, MAXW, 0});
        send_vectors('{MAXW, MINW, MAXW}, '{MINW, MAXW, MINW}, '{MAXW, MAXW, MINW});
        send_vectors('{MINW, 0, MAXW}, '{0, MINW, 0}, '{MINW, MINW, MINW});
        send_vectors('{1, 0, 0}, '{0, 0, 0}, '{0, 0, 1});
        send_vectors('{-1, -1, -1}, '{0, 0, 0}, '{1, 1, 1});
        send_vectors('{MAXW, 0, 0}, '{MINW, 0, 0}, '{0, 0, MAXW});
        send_vectors('{0, 0, MINW}, '{0, 0, 0}, '{0, MINW, 0});
        send_vectors('{ONE, ONE, 0}, '{0, 0, 0}, '{-ONE, -ONE, 0});
        send_vectors('{7, -3, 11}, '{-2, 5, 4}, '{MAXW, 1, MINW});
        send_vectors('{ONE - 1, 1 - ONE, ONE}, '{0, 0, 0}, '{ONE, 0, ONE});
        send_vectors('{MAXW, MAXW, MINW}, '{MAXW - 1, MAXW, MINW}, '{0, ONE, 0});

        for (int n = 0; n < N_RANDOM; n++) begin
            calm = (n >= 600 && n < 900);
            if (n == 1200) begin
                s_tvalid <= 1'b0;
                while (board.pending.size() != 0) @(posedge i_clk);
            end
            if ($urandom_range(9) == 0) begin
                for (int i = 0; i < 9; i++) d[i*W +: W] = $urandom;
            end else begin
                for (int i = 0; i < 3; i++) begin
                    e[i] = rnd_word();
                    t[i] = $urandom_range(5) == 0 ? e[i] : rnd_word();
                    u[i] = rnd_word();
                end
                // a share of cameras with a parallel or axis up vector
                if ($urandom_range(7) == 0) for (int i = 0; i < 3; i++) u[i] = e[i] - t[i];
                else if ($urandom_range(3) == 0) u = '{0, ONE, 0};
                d = {u[2], u[1], u[0], t[2], t[1], t[0], e[2], e[1], e[0]};
            end
            send_setup(d);
        end
        s_tvalid <= 1'b0;
        calm = 0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("look_at_view_matrix regression: pass");
        else
            $display("look_at_view_matrix regression: fail");
        $finish;
    end
endmodule
